### src/epsc_pkg.sv
package epsc_pkg;

  // Position counter width
  localparam int COUNT_WIDTH = 32;

  // Field widths
  localparam int SPEED_W  = 15;
  localparam int GAIN_W   = 8;
  localparam int PERIOD_W = 16;
  localparam int DATA_W   = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = CFG_IDX_W'(3);

  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = GAIN_W'(8);
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST = GAIN_W'(1);
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = GAIN_W'(10);
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = PERIOD_W'(8000);

  // Sample timing: 25 ms sample, 40 per second
  localparam int SAMPLE_MS  = 25;
  localparam int MS_PER_S   = 1000;
  localparam int INV_SAMPLE = 40;
  localparam int KD40_W     = GAIN_W + 6;

  // ki*e*25/1000 == ki*e/40 : shift by 3, then divide by 5
  localparam int INTEG_DIV   = MS_PER_S / SAMPLE_MS;
  localparam int DIV_SHIFT   = 3;
  localparam int DIV_CONST   = INTEG_DIV >> DIV_SHIFT;
  localparam int RECIP       = 3277;   // ceil(2^14 / 5)
  localparam int RECIP_SHIFT = 14;
  localparam int RECIP_W     = 12;

  // Digit-serial divider
  localparam int X_W        = GAIN_W + DATA_W + 1;
  localparam int DIGIT_W    = 8;
  localparam int DIV_DIGITS = 5;
  localparam int DIV_W      = DIGIT_W * DIV_DIGITS;
  localparam int DCNT_W     = $clog2(DIV_DIGITS);
  localparam int REM_W      = 3;
  localparam int V_W        = REM_W + DIGIT_W;
  localparam int PROD_W     = V_W + RECIP_W;

  typedef struct packed {
    logic pos_step;
    logic tick_load;
    logic calc_err;
    logic calc_mul;
    logic div_load;
    logic div_step;
    logic calc_int;
    logic calc_sum;
    logic finish;
  } epsc_cmd_t;

  typedef struct packed {
    logic div_last;
  } epsc_stat_t;

  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } epsc_cfg_wr_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

### src/epsc_in_if.sv
interface epsc_in_if;
  import epsc_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic               direction;
  logic [SPEED_W-1:0] desired_speed;

  modport source (output valid, output cmd, output direction, output desired_speed,
                  input ready);
  modport sink   (input valid, input cmd, input direction, input desired_speed,
                  output ready);
endinterface

### src/epsc_out_if.sv
interface epsc_out_if;
  import epsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PERIOD_W-1:0]      duty;
  logic signed [DATA_W-1:0] measured_speed;
  logic signed [DATA_W-1:0] speed_error;

  modport source (output valid, output duty, output measured_speed, output speed_error,
                  input ready);
  modport sink   (input valid, input duty, input measured_speed, input speed_error,
                  output ready);
endinterface

### src/epsc_cfg_if.sv
interface epsc_cfg_if;
  import epsc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/encoder_pid_speed_controller.sv
// Encoder-driven PID motor speed controller.
// in_ch  : one transaction per event. cmd 0 = encoder edge, which steps the
//          position count up (direction 1) or down (direction 0) and gives no
//          result. cmd 1 = sample tick, which runs the PID update and gives
//          exactly one result transaction on out_ch.
// out_ch : duty (clamped PWM compare, 1 .. period-1), measured speed and error.
// cfg_ch : register writes (0 kp, 1 ki, 2 kd, 3 PWM period), always ready;
//          write only while no tick is in flight.
// Steps  : an edge is taken in the idle state, back to back. A tick holds the
//          block, and in_ch is not ready, from acceptance until the tick
//          leaves its final step. The sequencer runs error, multiply, a
//          divider load, a 5-digit divide-by-5 stage for the integral term
//          (one byte a cycle), then integral, sum and accumulate steps.
// Stall  : the result sits in an output register. While it waits the block
//          still takes edges and starts the next tick; that tick holds in its
//          final step until the previous result is taken.
// Reset  : rst_n (synchronous, active low) restores the default gains and
//          period 8000 and clears position, integral, error and duty history.
module encoder_pid_speed_controller (
  input logic      clk,
  input logic      rst_n,
  epsc_in_if.sink  in_ch,
  epsc_out_if.source out_ch,
  epsc_cfg_if.sink cfg_ch
);
  import epsc_pkg::*;

  epsc_cmd_t    cmd;
  epsc_stat_t   stat;
  epsc_cfg_wr_t cfg_wr;

  // registers take a write every cycle
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.wr    = cfg_ch.valid;
  assign cfg_wr.idx   = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  epsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  epsc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_wr             (cfg_wr),
    .in_direction       (in_ch.direction),
    .in_desired_speed   (in_ch.desired_speed),
    .out_duty           (out_ch.duty),
    .out_measured_speed (out_ch.measured_speed),
    .out_speed_error    (out_ch.speed_error)
  );

endmodule

### src/epsc_ctrl.sv
module epsc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output epsc_pkg::epsc_cmd_t  cmd,
  input  epsc_pkg::epsc_stat_t stat
);
  import epsc_pkg::*;

  localparam logic CMD_TICK = 1'b1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ERR  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DLD  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_INT  = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;
  localparam logic [2:0] ST_ACC  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc, out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_TICK) begin
            cmd.tick_load = 1'b1;
            state_nxt     = ST_ERR;
          end else begin
            cmd.pos_step = 1'b1;
          end
        end
      end
      ST_ERR: begin
        cmd.calc_err = 1'b1;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.calc_mul = 1'b1;
        state_nxt    = ST_DLD;
      end
      ST_DLD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_INT;
        end
      end
      ST_INT: begin
        cmd.calc_int = 1'b1;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        cmd.calc_sum = 1'b1;
        state_nxt    = ST_ACC;
      end
      ST_ACC: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_stall_holds_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && out_valid_r && !out_ready) |=> (state_r == ST_ACC))
    else $error("final step did not wait for a stalled result");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && stat.div_last) |=> (state_r == ST_INT))
    else $error("divider exit missed");
`endif

endmodule

### src/epsc_dp.sv
module epsc_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  epsc_pkg::epsc_cmd_t                cmd,
  output epsc_pkg::epsc_stat_t               stat,
  input  epsc_pkg::epsc_cfg_wr_t             cfg_wr,
  input  logic                               in_direction,
  input  logic [epsc_pkg::SPEED_W-1:0]       in_desired_speed,
  output logic [epsc_pkg::PERIOD_W-1:0]      out_duty,
  output logic signed [epsc_pkg::DATA_W-1:0] out_measured_speed,
  output logic signed [epsc_pkg::DATA_W-1:0] out_speed_error
);
  import epsc_pkg::*;

  // Configuration
  logic [GAIN_W-1:0]   prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [PERIOD_W-1:0] pwm_period_r;

  // Controller state
  logic [COUNT_WIDTH-1:0]   pos_r, last_pos_r;
  logic signed [DATA_W-1:0] last_err_r, integ_r, duty_acc_r;

  // Working registers
  logic [SPEED_W-1:0]       desired_r;
  logic signed [DATA_W-1:0] speed_r, err_r, derr_r, p_r, d_r, sum_r;
  logic signed [X_W-1:0]    x_r;
  logic [DIV_W-1:0]         div_m_r, div_q_r;
  logic [REM_W-1:0]         div_rem_r;
  logic                     div_neg_r;
  logic [DCNT_W-1:0]        dcnt_r;

  // Result registers
  logic [PERIOD_W-1:0]      out_duty_r;
  logic signed [DATA_W-1:0] out_speed_r, out_err_r;

  // Combinational
  logic [COUNT_WIDTH-1:0]        diff;
  logic signed [DATA_W-1:0]      speed_nxt, abs_speed, err_nxt, derr_nxt, p_nxt, d_nxt;
  logic signed [X_W-1:0]         p_full, x_full;
  logic [KD40_W-1:0]             kd40;
  logic signed [KD40_W+DATA_W:0] d_full;
  logic [X_W-1:0]                x_mag;
  logic [DIGIT_W-1:0]            digit, q_dig;
  logic [V_W-1:0]                v;
  logic [PROD_W-1:0]             prod;
  logic [REM_W-1:0]              rem_nxt;
  logic signed [DIV_W:0]         q_s;
  logic signed [DATA_W-1:0]      inc, integ_nxt, sum_nxt, acc, acc_hi, acc_nxt, period_s;

  always_comb begin
    diff      = pos_r - last_pos_r;
    speed_nxt = sat32(64'(signed'(diff)));
    abs_speed = (speed_r == 32'sh80000000) ? 32'sh7fffffff :
                ((speed_r < 0) ? -speed_r : speed_r);
    err_nxt   = sat32(64'($signed({1'b0, desired_r})) - 64'(abs_speed));
    derr_nxt  = sat32(64'(err_r) - 64'(last_err_r));

    p_full = $signed({1'b0, prop_gain_r}) * err_r;
    x_full = $signed({1'b0, integ_gain_r}) * err_r;
    p_nxt  = sat32(64'(p_full));

    kd40   = KD40_W'(deriv_gain_r) * KD40_W'(INV_SAMPLE);
    d_full = $signed({1'b0, kd40}) * derr_r;
    d_nxt  = sat32(64'(d_full));

    // magnitude of ki*e; truncation toward zero is done on the magnitude
    x_mag = X_W'((x_r < 0) ? -x_r : x_r);

    // one quotient digit: (rem*256 + digit) / 5 by reciprocal
    digit   = div_m_r[DIV_W-1 -: DIGIT_W];
    v       = {div_rem_r, digit};
    prod    = PROD_W'(v) * PROD_W'(RECIP);
    q_dig   = DIGIT_W'(prod >> RECIP_SHIFT);
    rem_nxt = REM_W'(v - V_W'(q_dig) * V_W'(DIV_CONST));

    q_s       = div_neg_r ? -$signed({1'b0, div_q_r}) : $signed({1'b0, div_q_r});
    inc       = sat32(64'(q_s));
    integ_nxt = sat32(64'(integ_r) + 64'(inc));

    sum_nxt = sat32(64'(p_r) + 64'(d_r) + 64'(integ_r));

    // upper clamp first, then lower
    acc      = sat32(64'(duty_acc_r) + 64'(sum_r));
    period_s = signed'(DATA_W'(pwm_period_r));
    acc_hi   = (acc >= period_s) ? (period_s - 32'sd1) : acc;
    acc_nxt  = (acc_hi <= 32'sd0) ? 32'sd1 : acc_hi;
  end

  assign stat.div_last = (dcnt_r == DCNT_W'(DIV_DIGITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      pwm_period_r <= PWM_PERIOD_RST;
      pos_r        <= '0;
      last_pos_r   <= '0;
      last_err_r   <= '0;
      integ_r      <= '0;
      duty_acc_r   <= '0;
      dcnt_r       <= '0;
    end else begin
      if (cfg_wr.wr) begin
        case (cfg_wr.idx)
          REG_PROP_GAIN:  prop_gain_r  <= cfg_wr.data[GAIN_W-1:0];
          REG_INTEG_GAIN: integ_gain_r <= cfg_wr.data[GAIN_W-1:0];
          REG_DERIV_GAIN: deriv_gain_r <= cfg_wr.data[GAIN_W-1:0];
          REG_PWM_PERIOD: pwm_period_r <= cfg_wr.data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.pos_step) begin
        pos_r <= in_direction ? (pos_r + COUNT_WIDTH'(1)) : (pos_r - COUNT_WIDTH'(1));
      end
      if (cmd.tick_load) begin
        last_pos_r <= pos_r;
      end
      if (cmd.div_load) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      if (cmd.calc_int) begin
        integ_r <= integ_nxt;
      end
      if (cmd.finish) begin
        duty_acc_r <= acc_nxt;
        last_err_r <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_load) begin
      desired_r <= in_desired_speed;
      speed_r   <= speed_nxt;
    end
    if (cmd.calc_err) begin
      err_r <= err_nxt;
    end
    if (cmd.calc_mul) begin
      p_r    <= p_nxt;
      x_r    <= x_full;
      derr_r <= derr_nxt;
    end
    if (cmd.div_load) begin
      d_r       <= d_nxt;
      div_m_r   <= DIV_W'(x_mag >> DIV_SHIFT);
      div_neg_r <= (x_r < 0);
      div_rem_r <= '0;
      div_q_r   <= '0;
    end else if (cmd.div_step) begin
      div_m_r   <= div_m_r << DIGIT_W;
      div_q_r   <= {div_q_r[DIV_W-DIGIT_W-1:0], q_dig};
      div_rem_r <= rem_nxt;
    end
    if (cmd.calc_sum) begin
      sum_r <= sum_nxt;
    end
    if (cmd.finish) begin
      out_duty_r  <= acc_nxt[PERIOD_W-1:0];
      out_speed_r <= speed_r;
      out_err_r   <= err_r;
    end
  end

  assign out_duty           = out_duty_r;
  assign out_measured_speed = out_speed_r;
  assign out_speed_error    = out_err_r;

`ifndef SYNTH
  a_duty_positive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (duty_acc_r > 32'sd0))
    else $error("duty accumulator not clamped above zero");

  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc_err |=> (err_r <= 32'sd32767))
    else $error("speed error above desired range");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (div_rem_r < REM_W'(DIV_CONST)))
    else $error("divider remainder out of range");
`endif

endmodule

### dv/tb_encoder_pid_speed_controller.sv
`timescale 1ns / 1ps

// Testbench for the encoder PID speed controller.
// Encoder-edge and sample-tick transactions go in on in_ch. Each accepted tick
// runs through a local copy of the controller, which holds its own position,
// error history, integral and duty accumulator. The expected result is queued.
// The receiver pops the oldest entry for each result transaction and compares
// it field by field.
module tb_encoder_pid_speed_controller;
  import epsc_pkg::*;

  // An index that decodes to no register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(8'hC5);

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct {
    logic [PERIOD_W-1:0]      duty;
    logic signed [DATA_W-1:0] speed;
    logic signed [DATA_W-1:0] err;
  } pid_result_t;

  logic clk;
  logic rst_n;

  epsc_in_if  in_bus ();
  epsc_out_if out_bus ();
  epsc_cfg_if cfg_bus ();

  encoder_pid_speed_controller dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local controller copy: registers and state as they stand after reset
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]        kp_q       = PROP_GAIN_RST;
  logic [GAIN_W-1:0]        ki_q       = INTEG_GAIN_RST;
  logic [GAIN_W-1:0]        kd_q       = DERIV_GAIN_RST;
  logic [PERIOD_W-1:0]      period_q   = PWM_PERIOD_RST;
  logic [COUNT_WIDTH-1:0]   pos_q      = '0;
  logic [COUNT_WIDTH-1:0]   last_pos_q = '0;
  logic signed [DATA_W-1:0] last_err_q = '0;
  logic signed [DATA_W-1:0] integ_q    = '0;
  logic signed [DATA_W-1:0] acc_q      = '0;

  pid_result_t expected_pid_q[$];

  int fail_count = 0;

  // Idling controls, set per test
  bit src_gaps  = 1'b0;
  bit sink_gaps = 1'b0;
  int hold_left = 0;    // long receiver hold-off, counted down by the receiver

  function automatic logic signed [DATA_W-1:0] clip32(input longint v);
    if (v > S32_MAX) return DATA_W'(S32_MAX);
    if (v < S32_MIN) return DATA_W'(S32_MIN);
    return DATA_W'(v);
  endfunction

  function automatic void step_position(input logic dir);
    pos_q = dir ? pos_q + 1'b1 : pos_q - 1'b1;
  endfunction

  // One controller update; queues the result it must produce
  function automatic void predict_tick(input logic [SPEED_W-1:0] target);
    logic [COUNT_WIDTH-1:0] delta;
    longint kpl, kil, kdl, perl, w;
    longint spd, mag, e, de, p, d, inc, total, a;
    pid_result_t r;
    kpl = kp_q;
    kil = ki_q;
    kdl = kd_q;
    perl = period_q;
    w = target;
    // speed: counter difference read as signed, wrap included
    delta = pos_q - last_pos_q;
    spd = $signed(delta);
    spd = clip32(spd);
    last_pos_q = pos_q;
    // the most negative speed has no positive twin: saturate
    mag = (spd == S32_MIN) ? S32_MAX : ((spd < 0) ? -spd : spd);
    e = clip32(w - mag);
    p = clip32(kpl * e);
    de = clip32(e - last_err_q);
    d = clip32(kdl * de * INV_SAMPLE);
    // signed divide truncates toward zero
    inc = clip32(kil * e * SAMPLE_MS / MS_PER_S);
    integ_q = clip32(integ_q + inc);
    total = clip32(p + d + integ_q);
    a = clip32(acc_q + total);
    // upper clamp first, then lower: period 0 or 1 ends at 1
    if (a >= perl) a = perl - 1;
    if (a <= 0) a = 1;
    acc_q = DATA_W'(a);
    last_err_q = DATA_W'(e);
    r.duty = PERIOD_W'(a);
    r.speed = DATA_W'(spd);
    r.err = DATA_W'(e);
    expected_pid_q.push_back(r);
  endfunction

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Drives one transaction and holds it until accepted. valid is left high so
  // that the next call can follow back to back; gaps lower it first.
  task automatic send_event(input logic is_tick, input logic dir,
                            input logic [SPEED_W-1:0] target);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_bus.valid         <= 1'b0;
      in_bus.cmd           <= 1'($urandom);
      in_bus.direction     <= 1'($urandom);
      in_bus.desired_speed <= SPEED_W'($urandom);
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.cmd           <= is_tick;
    in_bus.direction     <= dir;
    in_bus.desired_speed <= target;
    do @(posedge clk); while (!in_bus.ready);
    if (is_tick) predict_tick(target);
    else step_position(dir);
  endtask

  // Quiesce: stop offering, let all results out, then cover an edge still in
  // flight (no result to wait for) before any register write.
  task automatic wait_idle;
    in_bus.valid <= 1'b0;
    while (expected_pid_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration side
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_PROP_GAIN:  kp_q = data[GAIN_W-1:0];
      REG_INTEG_GAIN: ki_q = data[GAIN_W-1:0];
      REG_DERIV_GAIN: kd_q = data[GAIN_W-1:0];
      REG_PWM_PERIOD: period_q = data[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                          input logic [CFG_DATA_W-1:0] kd, input logic [CFG_DATA_W-1:0] per);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_PWM_PERIOD, per);
    cfg_bus.valid <= 1'b0;
  endtask

  // gains: zero, full scale, or anything (upper data bits are don't-care)
  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CFG_DATA_W'(8'hFF);
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_period();
    case ($urandom_range(0, 7))
      0:       return CFG_DATA_W'($urandom_range(0, 1));
      1:       return CFG_DATA_W'(2);
      2:       return '1;
      3, 4:    return CFG_DATA_W'($urandom_range(2, 400));
      default: return CFG_DATA_W'($urandom_range(2, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready bursts, long hold-off on request, checking
  // ---------------------------------------------------------------------------
  task automatic check_result;
    pid_result_t want;
    if (expected_pid_q.size() == 0) begin
      note_fail($sformatf("result with nothing pending: duty=%0d speed=%0d error=%0d",
                          out_bus.duty, out_bus.measured_speed, out_bus.speed_error));
    end else begin
      want = expected_pid_q.pop_front();
      if (out_bus.duty !== want.duty)
        note_fail($sformatf("duty: expected %0d, got %0d", want.duty, out_bus.duty));
      if (out_bus.measured_speed !== want.speed)
        note_fail($sformatf("measured_speed: expected %0d, got %0d",
                            want.speed, out_bus.measured_speed));
      if (out_bus.speed_error !== want.err)
        note_fail($sformatf("speed_error: expected %0d, got %0d",
                            want.err, out_bus.speed_error));
    end
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values: first tick with nothing moving, counter wrap below zero,
  // both error signs, both clamps at the default period.
  task automatic test_reset_defaults;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    send_event(1'b1, 1'b1, '0);              // duty pinned low at 1
    send_event(1'b0, 1'b0, '1);              // count down through zero
    send_event(1'b0, 1'b0, 15'h5555);
    send_event(1'b0, 1'b0, 15'h2AAA);
    send_event(1'b1, 1'b0, '1);              // speed -3, full-scale target
    send_event(1'b0, 1'b1, '0);
    send_event(1'b0, 1'b1, '1);
    send_event(1'b1, 1'b1, '0);              // negative error
    send_event(1'b1, 1'b0, 15'd1);
    send_event(1'b1, 1'b1, '1);              // drive into period-1
    send_event(1'b1, 1'b0, '1);
    wait_idle();
  endtask

  // Gain and period extremes, including junk in the upper data bits and the
  // degenerate periods 0 and 1.
  task automatic test_gain_extremes;
    set_regs(16'hFF00, 16'h5A00, 16'h0100, 16'hFFFF);
    send_event(1'b0, 1'b1, '1);
    send_event(1'b1, 1'b0, '1);
    send_event(1'b1, 1'b1, '0);
    wait_idle();
    set_regs(16'h00FF, 16'hA5FF, 16'hFFFF, 16'h0002);
    send_event(1'b1, 1'b1, '1);
    send_event(1'b0, 1'b0, 15'h1234);
    send_event(1'b0, 1'b0, 15'h4321);
    send_event(1'b0, 1'b0, '0);
    send_event(1'b1, 1'b0, '0);
    wait_idle();
    write_reg(REG_PWM_PERIOD, 16'h0001);
    write_reg(REG_UNUSED, 16'h1234);         // decodes to nothing
    cfg_bus.valid <= 1'b0;
    send_event(1'b1, 1'b0, '1);
    wait_idle();
    write_reg(REG_PWM_PERIOD, 16'h0000);
    cfg_bus.valid <= 1'b0;
    send_event(1'b1, 1'b1, 15'd100);
    wait_idle();
  endtask

  // Mostly motor-like traffic: a run of edges in one direction with the odd
  // reversal, then a tick whose target sits near the speed or anywhere.
  // The rest is single random transactions.
  task automatic test_random_traffic;
    int ph, sent, k, i;
    logic drift;
    logic [SPEED_W-1:0] target;
    for (ph = 0; ph < 5; ph++) begin
      wait_idle();
      set_regs(pick_gain(), pick_gain(), pick_gain(), pick_period());
      src_gaps  = (ph != 0 && ph != 3);
      sink_gaps = (ph != 0 && ph != 2);
      sent = 0;
      while (sent < 160) begin
        if ($urandom_range(0, 9) < 8) begin
          k = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 24);
          drift = 1'($urandom);
          for (i = 0; i < k; i++)
            send_event(1'b0, ($urandom_range(0, 7) == 0) ? ~drift : drift, SPEED_W'($urandom));
          case ($urandom_range(0, 3))
            0:       target = SPEED_W'(k + $urandom_range(0, 3));
            1:       target = SPEED_W'($urandom_range(0, 64));
            2:       target = '1;
            default: target = SPEED_W'($urandom);
          endcase
          send_event(1'b1, 1'($urandom), target);
          sent += k + 1;
        end else begin
          send_event(1'($urandom), 1'($urandom), SPEED_W'($urandom));
          sent++;
        end
      end
    end
    wait_idle();
  endtask

  // Receiver stops for a long stretch while ticks keep coming, so the output
  // register and the following tick fill and in_ch must stall.
  task automatic test_output_backpressure;
    int i, j;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    set_regs(CFG_DATA_W'(20), CFG_DATA_W'(3), CFG_DATA_W'(7), CFG_DATA_W'(30000));
    hold_left = 400;
    for (i = 0; i < 8; i++) begin
      for (j = 0; j < 3; j++) send_event(1'b0, 1'($urandom), SPEED_W'($urandom));
      send_event(1'b1, 1'($urandom), SPEED_W'($urandom));
    end
    wait_idle();
  endtask

  // Full-scale target with the motor stalled: the integral winds up and the
  // duty sits at its upper clamp. Then pull the error negative so the large
  // derivative step drives the duty down to its lower clamp. No idling from
  // here on.
  task automatic test_integral_windup;
    int i, j;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    set_regs(16'h00FF, 16'h00FF, 16'h00FF, 16'hFFFF);
    for (i = 0; i < 120; i++) send_event(1'b1, 1'(i), '1);
    for (i = 0; i < 6; i++) begin
      for (j = 0; j < 20; j++) send_event(1'b0, 1'b1, SPEED_W'($urandom));
      send_event(1'b1, 1'($urandom), '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.cmd           <= 1'b0;
    in_bus.direction     <= 1'b0;
    in_bus.desired_speed <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.data         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_gain_extremes();
    test_random_traffic();
    test_output_backpressure();
    test_integral_windup();

    // drain, then a tail for anything stray
    in_bus.valid <= 1'b0;
    while (expected_pid_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
